@@ rtl/dti_pkg.sv @@
// dti_pkg: types and constants shared by the decision tree inference unit
// request and result payloads, opcodes, controller command and status bundles
// no dependencies
package dti_pkg;

	localparam int NODE_IDX_W    = 10;
	localparam int VAR_IDX_W     = 8;
	localparam int VAL_W         = 48;
	localparam int FRAC_W        = 16;
	localparam int NODE_ADDR_MAX = 1 << NODE_IDX_W;
	localparam int VAR_ADDR_MAX  = 1 << VAR_IDX_W;

	localparam logic [1:0] OP_NODE    = 2'd0;
	localparam logic [1:0] OP_FEATURE = 2'd1;
	localparam logic [1:0] OP_KIND    = 2'd2;
	localparam logic [1:0] OP_PREDICT = 2'd3;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [NODE_IDX_W-1:0]   node_index;
		logic [NODE_IDX_W-1:0]   left_child;
		logic [NODE_IDX_W-1:0]   right_child;
		logic [VAR_IDX_W-1:0]    split_variable;
		logic signed [VAL_W-1:0] split_thresh;
		logic [VAR_IDX_W-1:0]    feature_index;
		logic signed [VAL_W-1:0] feature_value;
		logic                    ordered_flag;
	} dti_req_t;

	typedef struct packed {
		logic [NODE_IDX_W-1:0] terminal_node;
		logic                  walk_overflow;
	} dti_rsp_t;

	typedef struct packed {
		logic [NODE_IDX_W-1:0]   left;
		logic [NODE_IDX_W-1:0]   right;
		logic [VAR_IDX_W-1:0]    var_sel;
		logic signed [VAL_W-1:0] split;
	} dti_node_t;

	typedef struct packed {
		logic clr_wr;
		logic load;
		logic walk_init;
		logic node_rd;
		logic feat_rd;
		logic advance;
		logic finish;
		logic finish_ovf;
	} dti_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic node_in_range;
		logic leaf;
		logic steps_full;
	} dti_sts_t;

endpackage

@@ rtl/dti_ctrl.sv @@
// dti_ctrl: sequencing state machine for table clearing, loads and tree walks
// depends on dti_pkg for the request, command and status types
module dti_ctrl import dti_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     [1:0] opcode,
	input  dti_sts_t sts,
	output dti_cmd_t cmd,
	output logic     busy,
	output logic     done
);

	localparam logic [2:0] ST_CLEAR     = 3'd0;
	localparam logic [2:0] ST_IDLE      = 3'd1;
	localparam logic [2:0] ST_RD_NODE   = 3'd2;
	localparam logic [2:0] ST_EVAL_NODE = 3'd3;
	localparam logic [2:0] ST_EVAL_FEAT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (opcode == OP_PREDICT) begin
						cmd.walk_init = 1'b1;
						state_d       = ST_RD_NODE;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_RD_NODE: begin
				if (!sts.node_in_range) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.node_rd = 1'b1;
					state_d     = ST_EVAL_NODE;
				end
			end
			ST_EVAL_NODE: begin
				if (sts.leaf) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (sts.steps_full) begin
					cmd.finish     = 1'b1;
					cmd.finish_ovf = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					cmd.feat_rd = 1'b1;
					state_d     = ST_EVAL_FEAT;
				end
			end
			ST_EVAL_FEAT: begin
				cmd.advance = 1'b1;
				state_d     = ST_RD_NODE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

@@ rtl/dti_datapath.sv @@
// dti_datapath: node, feature and variable-kind memories, walk registers, split test
// depends on dti_pkg; driven by commands from dti_ctrl
module dti_datapath import dti_pkg::*; #(
	parameter int NODES = 1024,
	parameter int VARS  = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  dti_req_t request,
	input  dti_cmd_t cmd,
	output dti_sts_t sts,
	output dti_rsp_t result
);

	localparam int NODE_DEPTH = (NODES < NODE_ADDR_MAX) ? NODES : NODE_ADDR_MAX;
	localparam int VAR_DEPTH  = (VARS < VAR_ADDR_MAX) ? VARS : VAR_ADDR_MAX;
	localparam int CLR_DEPTH  = (NODE_DEPTH > VAR_DEPTH) ? NODE_DEPTH : VAR_DEPTH;
	localparam int NAW        = $clog2(NODE_DEPTH);
	localparam int VAW        = (VAR_DEPTH > 1) ? $clog2(VAR_DEPTH) : 1;
	localparam int CW         = $clog2(CLR_DEPTH);
	localparam int SW         = $clog2(NODES + 1);
	localparam logic [31:0] NODES_U      = 32'(NODES);
	localparam logic [31:0] VARS_U       = 32'(VARS);
	localparam logic [31:0] NODE_DEPTH_U = 32'(NODE_DEPTH);
	localparam logic [31:0] VAR_DEPTH_U  = 32'(VAR_DEPTH);
	localparam int LVL_W = VAL_W - FRAC_W;

	dti_node_t               node_mem [NODE_DEPTH];
	logic signed [VAL_W-1:0] feat_mem [VAR_DEPTH];
	logic                    flag_mem [VAR_DEPTH];

	dti_node_t               node_rd_q;
	logic signed [VAL_W-1:0] feat_rd_q;
	logic                    flag_rd_q;
	logic                    var_ok_q;
	logic [NODE_IDX_W-1:0]   cur_node_q;
	logic [SW-1:0]           steps_q;
	logic [CW-1:0]           clr_cnt_q;
	dti_rsp_t                result_q;

	logic                    node_we;
	logic [NAW-1:0]          node_wa;
	dti_node_t               node_wd;
	logic                    feat_we;
	logic                    flag_we;
	logic [VAW-1:0]          flag_wa;
	logic                    flag_wd;
	logic                    var_ok;
	logic signed [VAL_W-1:0] value;
	logic                    ordered;
	logic signed [LVL_W-1:0] level;
	logic [LVL_W-1:0]        mask;
	logic [4:0]              bit_idx;
	logic                    go_left;

	// write port steering: clearing pass or load request
	always_comb begin
		node_we = 1'b0;
		node_wa = request.node_index[NAW-1:0];
		node_wd = '{left: request.left_child, right: request.right_child,
			var_sel: request.split_variable, split: request.split_thresh};
		flag_we = 1'b0;
		flag_wa = request.feature_index[VAW-1:0];
		flag_wd = request.ordered_flag;
		feat_we = cmd.load && (request.opcode == OP_FEATURE)
			&& (32'(request.feature_index) < VARS_U);
		if (cmd.clr_wr) begin
			node_we = (32'(clr_cnt_q) < NODE_DEPTH_U);
			node_wa = clr_cnt_q[NAW-1:0];
			node_wd = '0;
			flag_we = (32'(clr_cnt_q) < VAR_DEPTH_U);
			flag_wa = clr_cnt_q[VAW-1:0];
			flag_wd = 1'b1;
		end else begin
			node_we = cmd.load && (request.opcode == OP_NODE)
				&& (32'(request.node_index) < NODES_U);
			flag_we = cmd.load && (request.opcode == OP_KIND)
				&& (32'(request.feature_index) < VARS_U);
		end
	end

	assign var_ok = (32'(node_rd_q.var_sel) < VARS_U);

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_wa] <= node_wd;
		end
		if (cmd.node_rd) begin
			node_rd_q <= node_mem[cur_node_q[NAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (feat_we) begin
			feat_mem[request.feature_index[VAW-1:0]] <= request.feature_value;
		end
		if (cmd.feat_rd) begin
			feat_rd_q <= feat_mem[node_rd_q.var_sel[VAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
		if (cmd.feat_rd) begin
			flag_rd_q <= flag_mem[node_rd_q.var_sel[VAW-1:0]];
			var_ok_q  <= var_ok;
		end
	end

	// split test: ordered compare or categorical bitmask
	always_comb begin
		value   = var_ok_q ? feat_rd_q : '0;
		ordered = var_ok_q ? flag_rd_q : 1'b1;
		level   = value[VAL_W-1:FRAC_W];
		mask    = node_rd_q.split[VAL_W-1:FRAC_W];
		bit_idx = level[4:0] - 5'd1;
		if (ordered) begin
			go_left = (value <= node_rd_q.split);
		end else if ((level > LVL_W'(1'sb0)) && (level < LVL_W'(32))) begin
			go_left = !mask[bit_idx];
		end else begin
			go_left = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			cur_node_q <= '0;
			steps_q    <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + CW'(1);
			end
			if (cmd.walk_init) begin
				cur_node_q <= '0;
				steps_q    <= '0;
			end else if (cmd.advance) begin
				cur_node_q <= go_left ? node_rd_q.left : node_rd_q.right;
				steps_q    <= steps_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.terminal_node <= cur_node_q;
			result_q.walk_overflow <= cmd.finish_ovf;
		end
	end

	assign sts.clr_last      = (clr_cnt_q == CW'(CLR_DEPTH - 1));
	assign sts.node_in_range = (32'(cur_node_q) < NODES_U);
	assign sts.leaf          = (node_rd_q.left == '0) && (node_rd_q.right == '0);
	assign sts.steps_full    = (steps_q == SW'(NODES));
	assign result            = result_q;

endmodule

@@ rtl/decision_tree_inference_unit.sv @@
// Decision tree inference unit. After reset the node table is swept clear and the
// variable-kind flags are set to ordered, one entry per cycle, with busy high. A request
// is taken when start is high and busy is low. Node, feature and kind writes leave
// busy low. A prediction walks the tree from node 0; each internal node visited
// takes a node memory read, a feature and kind memory read and a split test, and the
// final node takes a node memory read and a leaf test, or no read when the final
// index is at or beyond NODES. busy falls at the same edge that raises done. done is
// high for a single cycle; result is registered and holds until the next walk ends;
// there is no backpressure, so it must be captured.
// A walk of NODES moves without reaching a leaf stops with walk_overflow set.
// depends on dti_pkg, dti_ctrl and dti_datapath
module decision_tree_inference_unit import dti_pkg::*; #(
	parameter int NODES = 1024,
	parameter int VARS  = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dti_req_t request,
	output logic     done,
	output dti_rsp_t result
);

	dti_cmd_t cmd;
	dti_sts_t sts;

	dti_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dti_datapath #(
		.NODES (NODES),
		.VARS  (VARS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a walk in progress");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_predict_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.opcode == OP_PREDICT)) |=> busy)
		else $error("prediction accepted but unit not busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.opcode != OP_PREDICT)) |=> (!busy && !done))
		else $error("load request disturbed idle state");

endmodule
